@@ rtl/core/concentric_disk_sample_core_macros.svh @@
// Assertion helpers shared by the core
`ifndef CONCENTRIC_DISK_SAMPLE_CORE_MACROS_SVH
`define CONCENTRIC_DISK_SAMPLE_CORE_MACROS_SVH

// same-cycle implication
`define CDS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cds assertion failed");

// next-cycle implication
`define CDS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cds assertion failed");

`endif

@@ rtl/core/cds_pkg.sv @@
`timescale 1ns / 1ps
package cds_pkg;
  localparam int INPUT_BITS_DEF  = 16;
  localparam int OUTPUT_BITS_DEF = 16;
  localparam int FRAC_BITS       = 30;
  localparam int QUO_BITS        = FRAC_BITS + 1;
  localparam logic [29:0] PI_OVER_4_Q30 = 30'd843314857;
  localparam int COS_STEPS = 6;
  localparam int SIN_STEPS = 5;
  localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};

  typedef struct packed {
    logic zero;
    logic swap;
    logic neg_a;
    logic neg_b;
  } cds_flags_t;
endpackage

@@ rtl/core/concentric_disk_sample_core.sv @@
`timescale 1ns / 1ps
// channel | dir | fields                 | handshake
// in      | rx  | u_fraction, v_fraction | in_valid / in_ready
// out     | tx  | disk_x, disk_y         | out_valid / out_ready
//
// One beat per cycle sustained while the result is not stalled.
// Most of the pipe depth comes from the 31-stage restoring divider for the angle ratio and
// the six Horner steps of the cosine series, three stages each.
// Reset clears the valid bits only; no clearing pass.
// A stalled result freezes the whole pipe: in_ready = !out_valid | out_ready.
module concentric_disk_sample_core #(
  parameter int INPUT_BITS  = cds_pkg::INPUT_BITS_DEF,
  parameter int OUTPUT_BITS = cds_pkg::OUTPUT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [INPUT_BITS-1:0]         u_fraction,
  input  logic [INPUT_BITS-1:0]         v_fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUTPUT_BITS-1:0] disk_x,
  output logic signed [OUTPUT_BITS-1:0] disk_y
);
  localparam int MW = INPUT_BITS + 1;

  logic                adv;
  logic [MW-1:0]       half;
  logic [MW-1:0]       two_u;
  logic [MW-1:0]       two_v;
  logic [MW-1:0]       ma;
  logic [MW-1:0]       mb;
  cds_pkg::cds_flags_t flags_next;

  logic                s_vld;
  cds_pkg::cds_flags_t s_flg;
  logic [MW-1:0]       s_big;
  logic [MW-1:0]       s_num;

  logic                      dv_vld;
  cds_pkg::cds_flags_t       dv_flg;
  logic [MW-1:0]             dv_big;
  logic [cds_pkg::QUO_BITS-1:0] dv_quo;

  logic                tg_vld;
  cds_pkg::cds_flags_t tg_flg;
  logic [MW-1:0]       tg_big;
  logic [30:0]         tg_sin;
  logic [30:0]         tg_cos;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign half  = MW'(1) << INPUT_BITS;
  assign two_u = {u_fraction, 1'b0};
  assign two_v = {v_fraction, 1'b0};

  always_comb begin
    flags_next.neg_a = ~u_fraction[INPUT_BITS-1];
    flags_next.neg_b = ~v_fraction[INPUT_BITS-1];
    ma = flags_next.neg_a ? half - two_u : two_u - half;
    mb = flags_next.neg_b ? half - two_v : two_v - half;
    flags_next.zero = (ma == '0) && (mb == '0);
    flags_next.swap = ma > mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_flg <= flags_next;
      s_big <= flags_next.swap ? ma : mb;
      s_num <= flags_next.swap ? mb : ma;
    end
  end

  cds_ratio_div #(
    .INPUT_BITS (INPUT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_vld),
    .in_flags  (s_flg),
    .in_big    (s_big),
    .in_num    (s_num),
    .out_valid (dv_vld),
    .out_flags (dv_flg),
    .out_big   (dv_big),
    .out_quo   (dv_quo)
  );

  cds_trig #(
    .INPUT_BITS (INPUT_BITS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dv_vld),
    .in_flags  (dv_flg),
    .in_big    (dv_big),
    .in_quo    (dv_quo),
    .out_valid (tg_vld),
    .out_flags (tg_flg),
    .out_big   (tg_big),
    .out_sin   (tg_sin),
    .out_cos   (tg_cos)
  );

  cds_scale #(
    .INPUT_BITS  (INPUT_BITS),
    .OUTPUT_BITS (OUTPUT_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (tg_vld),
    .in_flags  (tg_flg),
    .in_big    (tg_big),
    .in_sin    (tg_sin),
    .in_cos    (tg_cos),
    .out_valid (out_valid),
    .disk_x    (disk_x),
    .disk_y    (disk_y)
  );
endmodule

@@ rtl/core/cds_ratio_div.sv @@
`timescale 1ns / 1ps
module cds_ratio_div #(
  parameter int INPUT_BITS = cds_pkg::INPUT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  cds_pkg::cds_flags_t           in_flags,
  input  logic [INPUT_BITS:0]           in_big,
  input  logic [INPUT_BITS:0]           in_num,
  output logic                          out_valid,
  output cds_pkg::cds_flags_t           out_flags,
  output logic [INPUT_BITS:0]           out_big,
  output logic [cds_pkg::QUO_BITS-1:0]  out_quo
);
  localparam int QB = cds_pkg::QUO_BITS;
  localparam int RW = INPUT_BITS + 2;

  logic                vld [QB+1];
  cds_pkg::cds_flags_t flg [QB+1];
  logic [INPUT_BITS:0] den [QB+1];
  logic [RW-1:0]       rem [QB+1];
  logic [QB-1:0]       quo [QB+1];

  assign vld[0] = in_valid;
  assign flg[0] = in_flags;
  assign den[0] = in_big;
  assign rem[0] = RW'(in_num);
  assign quo[0] = '0;

  // one quotient bit per stage, restoring
  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          take;
    if (j == 0) begin : g_first
      assign trial = rem[j];
    end else begin : g_shift
      assign trial = {rem[j][RW-2:0], 1'b0};
    end
    assign take = trial >= RW'(den[j]);
    assign diff = trial - RW'(den[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        flg[j+1] <= flg[j];
        den[j+1] <= den[j];
        rem[j+1] <= take ? diff : trial;
        quo[j+1] <= {quo[j][QB-2:0], take};
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_flags = flg[QB];
  assign out_big   = den[QB];
  assign out_quo   = quo[QB];
endmodule

@@ rtl/core/cds_horner_step.sv @@
`timescale 1ns / 1ps
module cds_horner_step #(
  parameter int unsigned DIV = 2
) (
  input  logic        clk,
  input  logic        adv,
  input  logic [29:0] x2,
  input  logic [30:0] h_in,
  output logic [30:0] h_out
);
  localparam logic [29:0] RECIP = 30'((64'd1 << cds_pkg::FRAC_BITS) / DIV);
  localparam logic [30:0] DIV_W = 31'(DIV);
  localparam logic [30:0] ONE   = 31'(1) << cds_pkg::FRAC_BITS;

  logic [60:0] xh;
  logic [59:0] tr;
  logic [29:0] t_a;
  logic [29:0] t_b;
  logic [29:0] q_b;
  logic [30:0] qk;
  logic [30:0] rem;
  logic [30:0] qq;

  assign xh = 61'(x2) * 61'(h_in);
  assign tr = 60'(t_a) * 60'(RECIP);

  // reciprocal estimate is low by at most one
  assign qk  = 31'(q_b) * DIV_W;
  assign rem = {1'b0, t_b} - qk;
  assign qq  = 31'(q_b) + 31'(rem >= DIV_W);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_a   <= xh[59:30];
      t_b   <= t_a;
      q_b   <= tr[59:30];
      h_out <= ONE - qq;
    end
  end
endmodule

@@ rtl/core/cds_trig.sv @@
`timescale 1ns / 1ps
module cds_trig #(
  parameter int INPUT_BITS = cds_pkg::INPUT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  cds_pkg::cds_flags_t           in_flags,
  input  logic [INPUT_BITS:0]           in_big,
  input  logic [cds_pkg::QUO_BITS-1:0]  in_quo,
  output logic                          out_valid,
  output cds_pkg::cds_flags_t           out_flags,
  output logic [INPUT_BITS:0]           out_big,
  output logic [30:0]                   out_sin,
  output logic [30:0]                   out_cos
);
  localparam int NC = cds_pkg::COS_STEPS;
  localparam int NS = cds_pkg::SIN_STEPS;
  localparam int ND = 3 * NC;
  localparam logic [30:0] ONE = 31'(1) << cds_pkg::FRAC_BITS;

  logic [60:0]         pprod;
  logic [60:0]         prnd;
  logic                p_vld;
  cds_pkg::cds_flags_t p_flg;
  logic [INPUT_BITS:0] p_big;
  logic [29:0]         p_ang;
  logic [59:0]         sq;

  logic                d_vld [ND+1];
  cds_pkg::cds_flags_t d_flg [ND+1];
  logic [INPUT_BITS:0] d_big [ND+1];
  logic [29:0]         d_ang [ND+1];
  logic [29:0]         d_sq  [ND+1];

  logic [30:0] hc [NC+1];
  logic [30:0] hs [NC+1];
  logic [60:0] sp;

  assign pprod = 61'(in_quo) * 61'(cds_pkg::PI_OVER_4_Q30);
  assign prnd  = pprod + (61'd1 << (cds_pkg::FRAC_BITS - 1));
  assign sq    = 60'(p_ang) * 60'(p_ang);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld    <= 1'b0;
      d_vld[0] <= 1'b0;
    end else if (adv) begin
      p_vld    <= in_valid;
      d_vld[0] <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_flg    <= in_flags;
      p_big    <= in_big;
      p_ang    <= prnd[59:30];
      d_flg[0] <= p_flg;
      d_big[0] <= p_big;
      d_ang[0] <= p_ang;
      d_sq[0]  <= sq[59:30];
    end
  end

  for (genvar d = 1; d <= ND; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[d] <= 1'b0;
      end else if (adv) begin
        d_vld[d] <= d_vld[d-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_flg[d] <= d_flg[d-1];
        d_big[d] <= d_big[d-1];
        d_ang[d] <= d_ang[d-1];
        d_sq[d]  <= d_sq[d-1];
      end
    end
  end

  assign hc[0] = ONE;
  assign hs[0] = ONE;

  for (genvar i = 0; i < NC; i++) begin : g_horner
    cds_horner_step #(
      .DIV (cds_pkg::COS_DIV[i])
    ) u_cos (
      .clk   (clk),
      .adv   (adv),
      .x2    (d_sq[3*i]),
      .h_in  (hc[i]),
      .h_out (hc[i+1])
    );

    if (i < NS) begin : g_sin
      cds_horner_step #(
        .DIV (cds_pkg::SIN_DIV[i])
      ) u_sin (
        .clk   (clk),
        .adv   (adv),
        .x2    (d_sq[3*i]),
        .h_in  (hs[i]),
        .h_out (hs[i+1])
      );
    end else begin : g_sin_hold
      logic [30:0] h_d1;
      logic [30:0] h_d2;
      logic [30:0] h_d3;
      always_ff @(posedge clk) begin
        if (adv) begin
          h_d1 <= hs[i];
          h_d2 <= h_d1;
          h_d3 <= h_d2;
        end
      end
      assign hs[i+1] = h_d3;
    end
  end

  assign sp = 61'(d_ang[ND]) * 61'(hs[NC]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags <= d_flg[ND];
      out_big   <= d_big[ND];
      out_sin   <= sp[60:30];
      out_cos   <= hc[NC];
    end
  end
endmodule

@@ rtl/core/cds_scale.sv @@
`timescale 1ns / 1ps
`include "concentric_disk_sample_core_macros.svh"
module cds_scale #(
  parameter int INPUT_BITS  = cds_pkg::INPUT_BITS_DEF,
  parameter int OUTPUT_BITS = cds_pkg::OUTPUT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  cds_pkg::cds_flags_t           in_flags,
  input  logic [INPUT_BITS:0]           in_big,
  input  logic [30:0]                   in_sin,
  input  logic [30:0]                   in_cos,
  output logic                          out_valid,
  output logic signed [OUTPUT_BITS-1:0] disk_x,
  output logic signed [OUTPUT_BITS-1:0] disk_y
);
  localparam int PW = INPUT_BITS + 32;
  localparam int LW = PW + 1;
  localparam int SH = INPUT_BITS + 31 - OUTPUT_BITS;

  logic [30:0]         trig_x;
  logic [30:0]         trig_y;
  logic [PW-1:0]       prod_x_next;
  logic [PW-1:0]       prod_y_next;
  logic                m_vld;
  cds_pkg::cds_flags_t m_flg;
  logic [PW-1:0]       m_x;
  logic [PW-1:0]       m_y;

  function automatic logic [OUTPUT_BITS-1:0] round_sat(input logic [PW-1:0] prod,
                                                       input logic neg);
    logic [LW-1:0] sum;
    logic [LW-1:0] mag;
    logic [LW-1:0] negm;
    logic [LW-1:0] lim_pos;
    logic [LW-1:0] lim_neg;
    sum     = {1'b0, prod} + (LW'(1) << (SH - 1));
    mag     = sum >> SH;
    lim_neg = LW'(1) << (OUTPUT_BITS - 1);
    lim_pos = lim_neg - LW'(1);
    if (neg) begin
      if (mag > lim_neg) begin
        mag = lim_neg;
      end
      negm      = ~mag + LW'(1);
      round_sat = negm[OUTPUT_BITS-1:0];
    end else begin
      if (mag > lim_pos) begin
        mag = lim_pos;
      end
      round_sat = mag[OUTPUT_BITS-1:0];
    end
  endfunction

  assign trig_x      = in_flags.swap ? in_cos : in_sin;
  assign trig_y      = in_flags.swap ? in_sin : in_cos;
  assign prod_x_next = PW'(in_big) * PW'(trig_x);
  assign prod_y_next = PW'(in_big) * PW'(trig_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_vld     <= in_valid;
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_flg <= in_flags;
      m_x   <= prod_x_next;
      m_y   <= prod_y_next;
      if (m_flg.zero) begin
        disk_x <= '0;
        disk_y <= '0;
      end else begin
        disk_x <= $signed(round_sat(m_x, m_flg.neg_a));
        disk_y <= $signed(round_sat(m_y, m_flg.neg_b));
      end
    end
  end

  `CDS_ASSERT_NXT(a_x_sign, clk, rst, adv && m_vld && !m_flg.neg_a, !disk_x[OUTPUT_BITS-1])
  `CDS_ASSERT_NXT(a_y_sign, clk, rst, adv && m_vld && !m_flg.neg_b, !disk_y[OUTPUT_BITS-1])
  `CDS_ASSERT_NXT(a_centre, clk, rst, adv && m_vld && m_flg.zero, disk_x == 0 && disk_y == 0)
  `CDS_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !adv, out_valid)
endmodule

@@ tb/concentric_disk_sample_checker.sv @@
`timescale 1ns / 1ps
module concentric_disk_sample_checker #(
  parameter int INPUT_BITS  = 16,
  parameter int OUTPUT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [INPUT_BITS-1:0]         u_fraction,
  input  logic [INPUT_BITS-1:0]         v_fraction,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [OUTPUT_BITS-1:0] disk_x,
  input  logic signed [OUTPUT_BITS-1:0] disk_y,
  output int                            fail_count,
  output int                            pending,
  output int                            points_seen
);
  localparam logic [63:0] ONE = 64'd1 << 30;

  typedef struct packed {
    logic signed [OUTPUT_BITS-1:0] x;
    logic signed [OUTPUT_BITS-1:0] y;
  } disk_point_t;

  disk_point_t point_q[$];

  function automatic logic [63:0] angle_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = 0;
    if (rem >= den) begin
      rem = rem - den;
      quo = 1;
    end
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] horner(logic [63:0] p, bit is_sin);
    logic [63:0] sq;
    logic [63:0] h;
    int unsigned ks [6];
    int n;
    sq = (p * p) >> 30;
    h = ONE;
    if (is_sin) begin
      ks = '{110, 72, 42, 20, 6, 1};
      n = 5;
    end else begin
      ks = '{132, 90, 56, 30, 12, 2};
      n = 6;
    end
    for (int i = 0; i < n; i++) h = ONE - ((sq * h) >> 30) / ks[i];
    return is_sin ? (p * h) >> 30 : h;
  endfunction

  function automatic logic [OUTPUT_BITS-1:0] scale_coord(logic [63:0] mag,
                                                         logic [63:0] trig, bit neg);
    localparam int SH = INPUT_BITS + 31 - OUTPUT_BITS;
    logic [63:0] m;
    m = (mag * trig + (64'd1 << (SH - 1))) >> SH;
    if (neg) begin
      if (m > (64'd1 << (OUTPUT_BITS - 1))) m = 64'd1 << (OUTPUT_BITS - 1);
      return OUTPUT_BITS'(-m);
    end
    if (m > (64'd1 << (OUTPUT_BITS - 1)) - 1) m = (64'd1 << (OUTPUT_BITS - 1)) - 1;
    return OUTPUT_BITS'(m);
  endfunction

  function automatic disk_point_t map_to_disk(logic [INPUT_BITS-1:0] u,
                                              logic [INPUT_BITS-1:0] v);
    logic [63:0] half, ma, mb, big, p, s, c;
    bit na, nb;
    disk_point_t r;
    half = 64'd1 << INPUT_BITS;
    na = 2 * 64'(u) < half;
    nb = 2 * 64'(v) < half;
    ma = na ? half - 2 * 64'(u) : 2 * 64'(u) - half;
    mb = nb ? half - 2 * 64'(v) : 2 * 64'(v) - half;
    if (ma == 0 && mb == 0) return '0;
    if (ma > mb) begin
      big = ma;
      p = angle_ratio(mb, ma);
    end else begin
      big = mb;
      p = angle_ratio(ma, mb);
    end
    p = (p * 64'd843314857 + (64'd1 << 29)) >> 30;
    s = horner(p, 1);
    c = horner(p, 0);
    if (ma > mb) begin
      r.x = scale_coord(big, c, na);
      r.y = scale_coord(big, s, nb);
    end else begin
      r.x = scale_coord(big, s, na);
      r.y = scale_coord(big, c, nb);
    end
    return r;
  endfunction

  assign pending = point_q.size();

  always @(posedge clk) begin
    disk_point_t e;
    if (rst) begin
      fail_count <= 0;
      points_seen <= 0;
    end else begin
      if (in_valid && in_ready) point_q.push_back(map_to_disk(u_fraction, v_fraction));
      if (out_valid && out_ready) begin
        points_seen <= points_seen + 1;
        if (point_q.size() == 0) begin
          $display("%0t: unexpected beat x=%0d y=%0d", $time, disk_x, disk_y);
          fail_count <= fail_count + 1;
        end else begin
          e = point_q.pop_front();
          if (e.x !== disk_x || e.y !== disk_y) begin
            $display("%0t: mismatch expected x=%0d y=%0d actual x=%0d y=%0d",
                     $time, e.x, e.y, disk_x, disk_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_concentric_disk_sample_core.sv @@
`timescale 1ns / 1ps
module tb_concentric_disk_sample_core;
  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  logic [15:0] u_fraction, v_fraction;
  logic signed [15:0] disk_x, disk_y;
  int fail_count, pending, points_seen, cycles;
  int sent;

  concentric_disk_sample_core uut (.*);
  concentric_disk_sample_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  initial begin
    int g;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
      out_ready <= 1;
    end
  end

  task automatic send_point(logic [15:0] u, logic [15:0] v, bit burst);
    int g;
    if (!burst) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
    in_valid <= 1;
    u_fraction <= u;
    v_fraction <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  logic [15:0] edge_vals [10] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001,
                                  16'h4000, 16'hC000, 16'h0001, 16'h5555, 16'hAAAA};

  initial begin
    bit burst;
    rst = 1;
    in_valid = 0;
    u_fraction = 0;
    v_fraction = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    send_point(16'h8000, 16'h8000, 0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 5; j++) send_point(edge_vals[2*i+j/3], edge_vals[(i+3*j)%10], 1);
    in_valid <= 0;
    wait (pending == 0);
    burst = 0;
    for (int n = 0; n < 650; n++) begin
      if (n % 100 == 0) burst = !burst;
      case ($urandom_range(0, 5))
        0: send_point(16'h8000 ^ 16'($urandom_range(0, 3)), 16'($urandom), burst);
        1: begin
          logic [15:0] d;
          d = 16'($urandom);
          send_point(d, 16'hFFFF - d + 16'($urandom_range(0, 2)), burst);
        end
        default: send_point(16'($urandom), 16'($urandom),
                            burst && $urandom_range(0, 7) != 0);
      endcase
    end
    in_valid <= 0;
    wait (pending == 0);
    repeat (80) @(posedge clk);
    $display("covered %0d input beats, %0d results: centre, axes, diagonals, corners,",
             sent, points_seen);
    $display("random points with back-to-back bursts and stalls on both sides");
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
